/* rtl/quad_mask_composite_assert.svh */
// Assertion macros for the quad mask compositor.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef QUAD_MASK_COMPOSITE_ASSERT_SVH
`define QUAD_MASK_COMPOSITE_ASSERT_SVH

`ifndef SYNTHESIS
`define QMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QMC_ASSERT_NOW(lbl, ante, cons, msg)
`define QMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/qmc_pkg.sv */
// Shared types and constants for the quad mask compositor.
// No dependencies; imported by every module of the block.
package qmc_pkg;

    localparam int PIXEL_COORD_BITS = 12;
    localparam int COORD_W          = 12;
    localparam int CORNER_W         = 16;
    localparam int DIFF_W           = CORNER_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int EDGE_W           = PROD_W + 1;
    localparam int COLOR_W          = 8;
    localparam int RGB_W            = 3 * COLOR_W;
    localparam int NUM_CORNERS      = 4;

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << PIXEL_COORD_BITS) - 1);

    typedef enum logic [2:0] {
        REG_C0X = 3'd0,
        REG_C0Y = 3'd1,
        REG_C1X = 3'd2,
        REG_C1Y = 3'd3,
        REG_C2X = 3'd4,
        REG_C2Y = 3'd5,
        REG_C3X = 3'd6,
        REG_C3Y = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [CORNER_W-1:0] x;
        logic signed [CORNER_W-1:0] y;
    } point_t;

    typedef point_t [NUM_CORNERS-1:0] quad_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    typedef struct packed {
        logic pos;
        logic neg;
    } edge_sign_t;

endpackage

/* rtl/qmc_cfg.sv */
// Corner register file of the quad mask compositor.
// Depends on qmc_pkg for the register index codes and the quad type.
module qmc_cfg
    import qmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [CORNER_W-1:0] cfg_wdata,
    output quad_t               quad
);

    quad_t quad_reg;
    quad_t quad_next;

    always_comb
    begin
        quad_next = quad_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_addr))
                REG_C0X: quad_next[0].x = cfg_wdata;
                REG_C0Y: quad_next[0].y = cfg_wdata;
                REG_C1X: quad_next[1].x = cfg_wdata;
                REG_C1Y: quad_next[1].y = cfg_wdata;
                REG_C2X: quad_next[2].x = cfg_wdata;
                REG_C2Y: quad_next[2].y = cfg_wdata;
                REG_C3X: quad_next[3].x = cfg_wdata;
                REG_C3Y: quad_next[3].y = cfg_wdata;
                default: quad_next = quad_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg <= '0;
        end
        else
        begin
            quad_reg <= quad_next;
        end
    end

    assign quad = quad_reg;

endmodule

/* rtl/qmc_edge.sv */
// One edge function of the quad, evaluated over three register stages.
// Depends on qmc_pkg for widths, the corner type and the stage enables.
module qmc_edge
    import qmc_pkg::*;
(
    input  logic               clk,
    input  stage_en_t          en,
    input  logic [COORD_W-1:0] px,
    input  logic [COORD_W-1:0] py,
    input  point_t             corner_a,
    input  point_t             corner_b,
    output edge_sign_t         sign
);

    logic signed [DIFF_W-1:0] px_s;
    logic signed [DIFF_W-1:0] py_s;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, ex_next, ey_next;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p1_next, p2_next;
    logic signed [EDGE_W-1:0] e_val;
    edge_sign_t               sign_reg, sign_next;

    // Stage one: pixel offsets from corner a and the edge vector a to b.
    assign px_s    = $signed({{(DIFF_W-COORD_W){1'b0}}, px});
    assign py_s    = $signed({{(DIFF_W-COORD_W){1'b0}}, py});
    assign dx_next = px_s - DIFF_W'(corner_a.x);
    assign dy_next = py_s - DIFF_W'(corner_a.y);
    assign ex_next = DIFF_W'(corner_b.x) - DIFF_W'(corner_a.x);
    assign ey_next = DIFF_W'(corner_b.y) - DIFF_W'(corner_a.y);

    // Stage two: the two cross products.
    assign p1_next = ex_reg * dy_reg;
    assign p2_next = ey_reg * dx_reg;

    // Stage three: exact difference and its sign.
    assign e_val          = EDGE_W'(p1_reg) - EDGE_W'(p2_reg);
    assign sign_next.neg  = e_val[EDGE_W-1];
    assign sign_next.pos  = !e_val[EDGE_W-1] && (|e_val);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
        end
        if (en.s2)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (en.s3)
        begin
            sign_reg <= sign_next;
        end
    end

    assign sign = sign_reg;

endmodule

/* rtl/quad_mask_composite.sv */
// Top level of the quad mask compositor: stream ports, pipeline control,
// bounding box test and color select. Depends on qmc_pkg, qmc_cfg, qmc_edge.
//
//  Channel   Direction  Handshake         Content
//  s_*       in         tvalid / tready   pixel coordinates, fg and bg color
//  m_*       out        tvalid / tready   composited color, inside flag
//  cfg_*     in         cfg_wr_en only    corner registers 0..7
//
// Every pixel passes four register stages, and a new pixel can be accepted
// in every cycle while m_tready is high. The stages are the offsets and
// box compares, a 17 by 17 bit multiply, the exact subtraction with its
// sign test, and finally the color select into the output register.
// rst_n clears the valid bits and the corner registers asynchronously.
// When m_tready is low the stages fill up behind the output register, and a
// stage only moves when the one after it is empty or moving as well.
module quad_mask_composite
    import qmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input pixel stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low bit up: pixel_x[11:0], pixel_y[23:12], fg_red[31:24],
    // fg_green[39:32], fg_blue[47:40], bg_red[55:48], bg_green[63:56],
    // bg_blue[71:64].
    input  logic [71:0]          s_tdata,
    // Output pixel stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, low bit up: out_red[7:0], out_green[15:8], out_blue[23:16].
    output logic [23:0]          m_tdata,
    // m_tuser: inside_mask[0].
    output logic                 m_tuser,
    // Corner register write port.
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_addr,
    input  logic [CORNER_W-1:0]  cfg_wdata
);

    quad_t                       quad;
    logic [COORD_W-1:0]          px;
    logic [COORD_W-1:0]          py;
    logic signed [DIFF_W-1:0]    px_s;
    logic signed [DIFF_W-1:0]    py_s;
    stage_en_t                   en;
    logic                        en4;
    edge_sign_t [NUM_CORNERS-1:0] edge_sign;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [RGB_W-1:0]            fg1_reg, fg2_reg, fg3_reg;
    logic [RGB_W-1:0]            bg1_reg, bg2_reg, bg3_reg;
    logic                        box1_reg, box2_reg, box3_reg;
    logic                        box_next;
    logic [RGB_W-1:0]            rgb_reg, rgb_next;
    logic                        mask_reg, mask_next;
    logic [NUM_CORNERS-1:0]      lt_x, gt_x, lt_y, gt_y;
    logic [NUM_CORNERS-1:0]      any_pos_vec, any_neg_vec;

    // Register file for the four corners.
    qmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .quad      (quad)
    );

    // Coordinates are masked to the configured coordinate width.
    assign px   = s_tdata[11:0] & COORD_MASK;
    assign py   = s_tdata[23:12] & COORD_MASK;
    assign px_s = $signed({{(DIFF_W-COORD_W){1'b0}}, px});
    assign py_s = $signed({{(DIFF_W-COORD_W){1'b0}}, py});

    // A stage may load when it is empty or when its content moves on.
    assign en4      = !v4_reg || m_tready;
    assign en.s3    = !v3_reg || en4;
    assign en.s2    = !v2_reg || en.s3;
    assign en.s1    = !v1_reg || en.s2;
    assign s_tready = en.s1;

    // One edge unit per edge, taken cyclically 0-1, 1-2, 2-3, 3-0.
    for (genvar i = 0; i < NUM_CORNERS; i++)
    begin : g_edge
        qmc_edge u_edge (
            .clk      (clk),
            .en       (en),
            .px       (px),
            .py       (py),
            .corner_a (quad[i]),
            .corner_b (quad[(i + 1) % NUM_CORNERS]),
            .sign     (edge_sign[i])
        );
        assign lt_x[i]        = px_s < DIFF_W'(quad[i].x);
        assign gt_x[i]        = px_s > DIFF_W'(quad[i].x);
        assign lt_y[i]        = py_s < DIFF_W'(quad[i].y);
        assign gt_y[i]        = py_s > DIFF_W'(quad[i].y);
        assign any_pos_vec[i] = edge_sign[i].pos;
        assign any_neg_vec[i] = edge_sign[i].neg;
    end

    // The pixel is left of the box exactly when it is left of every corner,
    // and likewise for the other three sides, so no min/max chain is needed.
    assign box_next = !((&lt_x) || (&gt_x) || (&lt_y) || (&gt_y));

    // Inside needs the box test and no pair of edges of strictly opposite sign.
    assign mask_next = box3_reg && !((|any_pos_vec) && (|any_neg_vec));
    assign rgb_next  = mask_next ? fg3_reg : bg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            fg1_reg  <= s_tdata[47:24];
            bg1_reg  <= s_tdata[71:48];
            box1_reg <= box_next;
        end
        if (en.s2)
        begin
            fg2_reg  <= fg1_reg;
            bg2_reg  <= bg1_reg;
            box2_reg <= box1_reg;
        end
        if (en.s3)
        begin
            fg3_reg  <= fg2_reg;
            bg3_reg  <= bg2_reg;
            box3_reg <= box2_reg;
        end
        if (en4)
        begin
            rgb_reg  <= rgb_next;
            mask_reg <= mask_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = rgb_reg;
    assign m_tuser  = mask_reg;

    `include "quad_mask_composite_assert.svh"

    // The input side can only be held off by a stalled output.
    `QMC_ASSERT_NOW(a_backpressure_source, !s_tready, m_tvalid && !m_tready, "input stall")
    // A pixel in the last edge stage reaches the output when that stage moves.
    `QMC_ASSERT_NEXT(a_stage_to_output, v3_reg && en4, m_tvalid, "pixel lost before output")
    // A pixel outside the bounding box never comes out as inside.
    `QMC_ASSERT_NEXT(a_box_reject, v3_reg && en4 && !box3_reg, !m_tuser, "box reject")

endmodule
